// ----- design/qpe_pkg.sv -----
// shared types, constants and helpers for the quadrature phase emulator
package qpe_pkg;

  localparam int ENCODERS      = 2;
  localparam int FRACTION_BITS = 14;
  localparam int PIN_COUNT     = 5;
  localparam int POS_W         = 32;
  localparam int SUM_W         = POS_W + 2;
  localparam int LIMIT_W       = 16;
  localparam int ENC_W         = (ENCODERS > 1) ? $clog2(ENCODERS) : 1;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int REG_IDX_W     = 3;

  // register indexes, also the pin order in pin_level and pin_changed
  localparam logic [REG_IDX_W-1:0] REG_ROUTE_UP      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROUTE_DOWN    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROUTE_LEFT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROUTE_RIGHT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROUTE_TRIGGER = 3'd4;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // one whole quadrature step in position units
  localparam logic signed [POS_W-1:0] ONE_STEP = 32'sd1 <<< FRACTION_BITS;
  localparam logic signed [SUM_W-1:0] POS_MAX  = 34'sd2147483647;

  localparam logic [4:0] PINS_HIGH = 5'h1F;

  // pin routing: bit2 encoder number, bit1 phase select, bit0 encoder mode
  typedef struct packed {
    logic enc;
    logic phase;
    logic mode;
  } route_t;

  typedef route_t [PIN_COUNT-1:0] route_set_t;

  // tick results handed back to the top level
  typedef struct packed {
    logic [PIN_COUNT-1:0] levels;
    logic [PIN_COUNT-1:0] changed;
  } pin_result_t;

  // gray sequence 0, 2, 3, 1; phase picks the bit
  function automatic logic gray_bit(input logic [1:0] step, input logic phase);
    logic [1:0] g;
    begin
      unique case (step)
        2'd0: g = 2'd0;
        2'd1: g = 2'd2;
        2'd2: g = 2'd3;
        2'd3: g = 2'd1;
        default: g = 2'd0;
      endcase
      gray_bit = g[phase];
    end
  endfunction

endpackage

// ----- design/qpe_regs.sv -----
// apb routing registers of the quadrature phase emulator
module qpe_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qpe_pkg::ADDR_W-1:0]    paddr,
  input  logic [qpe_pkg::DATA_W-1:0]    pwdata,
  output logic [qpe_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output qpe_pkg::route_set_t           routes
);

  logic [qpe_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[qpe_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      routes <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        qpe_pkg::REG_ROUTE_UP:      routes[0] <= pwdata[2:0];
        qpe_pkg::REG_ROUTE_DOWN:    routes[1] <= pwdata[2:0];
        qpe_pkg::REG_ROUTE_LEFT:    routes[2] <= pwdata[2:0];
        qpe_pkg::REG_ROUTE_RIGHT:   routes[3] <= pwdata[2:0];
        qpe_pkg::REG_ROUTE_TRIGGER: routes[4] <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      qpe_pkg::REG_ROUTE_UP:      prdata[2:0] = routes[0];
      qpe_pkg::REG_ROUTE_DOWN:    prdata[2:0] = routes[1];
      qpe_pkg::REG_ROUTE_LEFT:    prdata[2:0] = routes[2];
      qpe_pkg::REG_ROUTE_RIGHT:   prdata[2:0] = routes[3];
      qpe_pkg::REG_ROUTE_TRIGGER: prdata[2:0] = routes[4];
      default:                    prdata      = '0;
    endcase
  end

endmodule

// ----- design/qpe_update.sv -----
// clamped add of a position delta
module qpe_update (
  input  logic signed [qpe_pkg::POS_W-1:0]   pos,
  input  logic signed [qpe_pkg::POS_W-1:0]   delta,
  input  logic        [qpe_pkg::LIMIT_W-1:0] limit_steps,
  output logic signed [qpe_pkg::POS_W-1:0]   pos_next
);

  logic signed [qpe_pkg::SUM_W-1:0] sum;
  logic signed [qpe_pkg::SUM_W-1:0] bound;
  logic signed [qpe_pkg::SUM_W-1:0] clamped;

  always_comb begin
    // sum kept two bits wider so it never wraps
    sum   = $signed({{2{pos[qpe_pkg::POS_W-1]}}, pos})
          + $signed({{2{delta[qpe_pkg::POS_W-1]}}, delta});
    bound = $signed({{(qpe_pkg::SUM_W - qpe_pkg::LIMIT_W){1'b0}}, limit_steps})
            <<< qpe_pkg::FRACTION_BITS;
    if (bound > qpe_pkg::POS_MAX) begin
      bound = qpe_pkg::POS_MAX;
    end
    clamped = sum;
    if (clamped > bound) begin
      clamped = bound;
    end
    if (clamped < -bound) begin
      clamped = -bound;
    end
    pos_next = clamped[qpe_pkg::POS_W-1:0];
  end

endmodule

// ----- design/qpe_tick.sv -----
// one timer tick: step each encoder that holds a whole step and rewrite the pins routed to it
module qpe_tick (
  input  logic signed [qpe_pkg::POS_W-1:0]     pos      [qpe_pkg::ENCODERS],
  input  logic        [1:0]                    step     [qpe_pkg::ENCODERS],
  input  qpe_pkg::route_set_t                  routes,
  input  logic        [qpe_pkg::PIN_COUNT-1:0] levels,
  output logic signed [qpe_pkg::POS_W-1:0]     pos_next [qpe_pkg::ENCODERS],
  output logic        [1:0]                    step_next[qpe_pkg::ENCODERS],
  output qpe_pkg::pin_result_t                 pins
);

  logic [qpe_pkg::ENCODERS-1:0] moved;

  always_comb begin
    for (int e = 0; e < qpe_pkg::ENCODERS; e++) begin
      pos_next[e]  = pos[e];
      step_next[e] = step[e];
      moved[e]     = 1'b0;
      if (pos[e] >= qpe_pkg::ONE_STEP) begin
        pos_next[e]  = pos[e] - qpe_pkg::ONE_STEP;
        step_next[e] = step[e] + 2'd1;
        moved[e]     = 1'b1;
      end else if (pos[e] <= -qpe_pkg::ONE_STEP) begin
        pos_next[e]  = pos[e] + qpe_pkg::ONE_STEP;
        step_next[e] = step[e] - 2'd1;
        moved[e]     = 1'b1;
      end
    end
  end

  // each pin follows at most one encoder, so encoder order does not matter
  always_comb begin
    pins.levels  = levels;
    pins.changed = '0;
    for (int p = 0; p < qpe_pkg::PIN_COUNT; p++) begin
      for (int e = 0; e < qpe_pkg::ENCODERS; e++) begin
        if (routes[p].mode && (routes[p].enc == 1'(e)) && moved[e]) begin
          pins.levels[p]  = qpe_pkg::gray_bit(step_next[e], routes[p].phase);
          pins.changed[p] = 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/quadrature_phase_emulator_core.sv -----
// top level of the quadrature phase emulator
//
// emulates two quadrature encoders on five pins (up, down, left, right,
// trigger). requests arrive on the in_valid / in_ready channel: op selects
// an update (clamped add of delta to one encoder position, 14 fraction
// bits) or a timer tick (each encoder moves at most one quadrature step).
// every request yields exactly one result on out_valid / out_ready with the
// pin levels after the request and the pins rewritten by a tick.
// routing is set through the apb port, one 3-bit register per pin at byte
// address 4*pin; write it only while no request is in flight.
// a request passes the input register, then the result register, with one
// add/compare pass between them. throughput: one request per cycle while
// the receiver keeps taking results.
// a stalled receiver holds the result register; the input register still
// takes one more request, then in_ready drops until the result is taken.
// reset (synchronous, active high) clears positions, steps and routes, sets
// the stored pin levels high and empties both registers.
module quadrature_phase_emulator_core (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic                               enc_index,
  input  logic signed [31:0]                 delta,
  input  logic        [15:0]                 limit_steps,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [4:0]                  pin_level,
  output logic        [4:0]                  pin_changed,
  // apb configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [qpe_pkg::ADDR_W-1:0]         paddr,
  input  logic [qpe_pkg::DATA_W-1:0]         pwdata,
  output logic [qpe_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  qpe_pkg::route_set_t routes;

  // input register
  logic                                 s1_valid;
  logic                                 s1_op;
  logic [qpe_pkg::ENC_W-1:0]            s1_enc;
  logic signed [qpe_pkg::POS_W-1:0]     s1_delta;
  logic [qpe_pkg::LIMIT_W-1:0]          s1_limit;

  // encoder state
  logic signed [qpe_pkg::POS_W-1:0]     position [qpe_pkg::ENCODERS];
  logic [1:0]                           quad_step[qpe_pkg::ENCODERS];
  logic [qpe_pkg::PIN_COUNT-1:0]        pin_levels;

  // compute results
  logic signed [qpe_pkg::POS_W-1:0]     upd_pos_next;
  logic signed [qpe_pkg::POS_W-1:0]     tick_pos_next [qpe_pkg::ENCODERS];
  logic [1:0]                           tick_step_next[qpe_pkg::ENCODERS];
  qpe_pkg::pin_result_t                 tick_pins;

  logic accept;
  logic out_free;
  logic advance;
  logic enc_in_range;

  // result register frees when empty or being taken
  assign out_free     = !out_valid || out_ready;
  assign advance      = s1_valid && out_free;
  assign in_ready     = !s1_valid || out_free;
  assign accept       = in_valid && in_ready;
  assign enc_in_range = (32'(s1_enc) < 32'(qpe_pkg::ENCODERS));

  qpe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .routes  (routes)
  );

  qpe_update u_update (
    .pos         (position[s1_enc]),
    .delta       (s1_delta),
    .limit_steps (s1_limit),
    .pos_next    (upd_pos_next)
  );

  qpe_tick u_tick (
    .pos       (position),
    .step      (quad_step),
    .routes    (routes),
    .levels    (pin_levels),
    .pos_next  (tick_pos_next),
    .step_next (tick_step_next),
    .pins      (tick_pins)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op    <= op;
      s1_enc   <= enc_index;
      s1_delta <= delta;
      s1_limit <= limit_steps;
    end
  end

  // encoder state advances when the request moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int e = 0; e < qpe_pkg::ENCODERS; e++) begin
        position[e]  <= '0;
        quad_step[e] <= '0;
      end
      pin_levels <= qpe_pkg::PINS_HIGH;
    end else if (advance) begin
      if (s1_op == qpe_pkg::OP_TICK) begin
        for (int e = 0; e < qpe_pkg::ENCODERS; e++) begin
          position[e]  <= tick_pos_next[e];
          quad_step[e] <= tick_step_next[e];
        end
        pin_levels <= tick_pins.levels;
      end else if (enc_in_range) begin
        position[s1_enc] <= upd_pos_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_op == qpe_pkg::OP_TICK) begin
        pin_level   <= tick_pins.levels;
        pin_changed <= tick_pins.changed;
      end else begin
        // updates leave the pins alone
        pin_level   <= pin_levels;
        pin_changed <= '0;
      end
    end
  end

endmodule
